>>> rtl/tcli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcli_pkg;

	// Table geometry and number format.
	localparam int TABLE_DEPTH  = 1024;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int SIZE_W       = IDX_W + 1;
	localparam int VAL_W        = 16;
	localparam int SAMPLE_W     = VAL_W + 1;
	localparam int POS_W        = VAL_W + IDX_W;
	localparam int PROD_W       = 2 * VAL_W + 2;
	localparam int BISECT_STEPS = 16;
	localparam int STEP_W       = $clog2(BISECT_STEPS);

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REQ_LOAD      = 2'd0,
		REQ_BUILD     = 2'd1,
		REQ_TO_LIN    = 2'd2,
		REQ_FROM_LIN  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_INDEX  = 2'd1,
		ST_BUILD_DONE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_TABLE_SIZE = 1'd0
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS,
		S_RDA,
		S_RDB,
		S_MUL,
		S_SUM,
		S_BGUESS,
		S_BMUL,
		S_BCMP,
		S_BWR,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

>>> rtl/tcli_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per load, build or lookup request.
interface tcli_req_if;
	logic                              valid;
	logic                              ready;
	tcli_pkg::req_type_t               req_type;
	logic [tcli_pkg::IDX_W-1:0]        entry_index;
	logic [tcli_pkg::VAL_W-1:0]        entry_value;
	logic [tcli_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, req_type, entry_index, entry_value, sample, input ready);
	modport sink   (input valid, req_type, entry_index, entry_value, sample, output ready);
endinterface

// Response channel: one word per request.
interface tcli_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcli_pkg::VAL_W-1:0]    value;
	tcli_pkg::status_t             status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

>>> rtl/tone_curve_lut_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake        | Word
// req     | in  | valid / ready    | req_type, entry_index, entry_value, sample
// rsp     | out | valid / ready    | value, status
// apb     | in  | psel/penable/... | table_size at byte address 0
//
// A load goes straight to its response; a lookup first reads the two adjacent
// table entries one after the other through the single read port, then multiplies.
// A build runs the 16 bisection steps for each entry in use; each step is a full
// forward lookup plus a scale multiply.
// One request is worked at a time; a new word is taken while a result waits in
// the output register. arst_n clears control state; table contents are not reset.
module tone_curve_lut_interpolator (
	input  wire                             clk,
	input  wire                             arst_n,
	tcli_req_if.sink                        req,
	tcli_rsp_if.source                      rsp,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [tcli_pkg::PADDR_W-1:0]     paddr,
	input  wire [tcli_pkg::PDATA_W-1:0]     pwdata,
	output logic [tcli_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import tcli_pkg::*;

	localparam logic [SAMPLE_W-1:0] ONE_S    = SAMPLE_W'(1) << VAL_W;
	localparam logic [VAL_W-1:0]    VAL_MAX  = '1;
	localparam logic [PROD_W-1:0]   HALF     = PROD_W'(1) << (VAL_W - 1);
	localparam logic [STEP_W-1:0]   LAST_STEP = STEP_W'(BISECT_STEPS - 1);

	// Memories.
	logic [VAL_W-1:0] fwd_mem [TABLE_DEPTH];
	logic [VAL_W-1:0] inv_mem [TABLE_DEPTH];
	logic [VAL_W-1:0] fwd_rd_q, inv_rd_q;

	// Control and datapath registers.
	state_t                state_q, state_d;
	logic [SIZE_W-1:0]     table_size_q;
	req_type_t             req_q;
	logic                  tab_inv_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [POS_W-1:0]      pos_q;
	logic                  clamp_q;
	logic [VAL_W-1:0]      a_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]      res_q;
	status_t               status_q;
	logic [POS_W-1:0]      r_q;
	logic [SAMPLE_W-1:0]   lo_q, hi_q;
	logic [STEP_W-1:0]     k_q;
	logic [IDX_W-1:0]      j_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      out_value_q;
	status_t               out_status_q;

	// Control outputs of the sequencer.
	logic                  req_fire;
	logic                  fwd_we, inv_we;
	logic [IDX_W-1:0]      rd_addr;
	logic                  out_load;
	logic                  out_free;

	// Combinational datapath.
	logic [IDX_W-1:0]      last;
	logic [IDX_W-1:0]      pos_idx;
	logic [VAL_W-1:0]      pos_frac;
	logic                  single;
	logic [VAL_W-1:0]      rd_data;
	logic [POS_W-1:0]      pos_d;
	logic signed [VAL_W:0] diff;
	logic signed [VAL_W:0] frac_s;
	logic signed [PROD_W-1:0] prod_d, sum_d;
	logic [POS_W-1:0]      r_d;
	logic [POS_W-1:0]      target;
	logic [SAMPLE_W:0]     guess_sum, fin_sum;
	logic [VAL_W-1:0]      inv_wdata;
	logic                  cfg_wr;

	// Effective table size, kept as the index of the last entry in use.
	always_comb begin
		unique if (table_size_q < SIZE_W'(2)) begin
			last = IDX_W'(1);
		end else if (table_size_q > SIZE_W'(TABLE_DEPTH)) begin
			last = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			last = IDX_W'(table_size_q - SIZE_W'(1));
		end
	end

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(256);
		end else if (cfg_wr) begin
			table_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (paddr[PADDR_W-1:2] == REG_TABLE_SIZE) begin
			prdata = PDATA_W'(table_size_q);
		end else begin
			prdata = '0;
		end
	end

	// Position split, interpolation and bisection arithmetic.
	assign pos_idx  = pos_q[POS_W-1:VAL_W];
	assign pos_frac = pos_q[VAL_W-1:0];
	assign single   = clamp_q || (pos_idx >= last) || (pos_frac == '0);
	assign rd_data  = tab_inv_q ? inv_rd_q : fwd_rd_q;
	assign pos_d    = POS_W'(sample_q[VAL_W-1:0]) * POS_W'(last);
	assign diff     = $signed({1'b0, rd_data}) - $signed({1'b0, a_q});
	assign frac_s   = $signed({1'b0, pos_frac});
	assign prod_d   = diff * frac_s;
	assign sum_d    = $signed({2'b00, a_q, VAL_W'(0)}) + prod_q + $signed(HALF);
	assign r_d      = POS_W'(res_q) * POS_W'(last);
	assign target   = {j_q, VAL_W'(0)};
	assign guess_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign fin_sum   = {1'b0, lo_q} + {1'b0, hi_q} + (SAMPLE_W + 1)'(1);
	assign inv_wdata = (fin_sum[SAMPLE_W:1] > SAMPLE_W'(VAL_MAX)) ? VAL_MAX
	                                                               : fin_sum[VAL_W:1];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.req_type)
						REQ_LOAD:     state_d = S_RESP;
						REQ_BUILD:    state_d = S_BGUESS;
						REQ_TO_LIN:   state_d = S_POS;
						REQ_FROM_LIN: state_d = S_POS;
					endcase
				end
			end
			S_POS:    state_d = S_RDA;
			S_RDA:    state_d = S_RDB;
			S_RDB:    state_d = S_MUL;
			S_MUL:    state_d = S_SUM;
			S_SUM:    state_d = (req_q == REQ_BUILD) ? S_BMUL : S_RESP;
			S_BGUESS: state_d = S_POS;
			S_BMUL:   state_d = S_BCMP;
			S_BCMP:   state_d = (k_q == LAST_STEP) ? S_BWR : S_BGUESS;
			S_BWR:    state_d = (j_q == last) ? S_RESP : S_BGUESS;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		req.ready = 1'b0;
		fwd_we    = 1'b0;
		inv_we    = 1'b0;
		out_load  = 1'b0;
		rd_addr   = pos_idx;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				fwd_we    = req.valid && (req.req_type == REQ_LOAD) && (req.entry_index <= last);
			end
			S_RDA: begin
				rd_addr = (clamp_q || (pos_idx >= last)) ? last : pos_idx;
			end
			S_RDB: begin
				rd_addr = pos_idx + IDX_W'(1);
			end
			S_BWR: begin
				inv_we = 1'b1;
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
				rd_addr = pos_idx;
			end
		endcase
	end

	assign req_fire = req.valid && req.ready;

	// Forward table.
	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[req.entry_index] <= req.entry_value;
		end
		fwd_rd_q <= fwd_mem[rd_addr];
	end

	// Inverse table.
	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[j_q] <= inv_wdata;
		end
		inv_rd_q <= inv_mem[rd_addr];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request and lookup datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					req_q     <= req.req_type;
					sample_q  <= req.sample;
					tab_inv_q <= (req.req_type == REQ_FROM_LIN);
					res_q     <= '0;
					lo_q      <= '0;
					hi_q      <= ONE_S;
					k_q       <= '0;
					j_q       <= '0;
					if (req.req_type == REQ_BUILD) begin
						status_q <= ST_BUILD_DONE;
					end else if ((req.req_type == REQ_LOAD) && (req.entry_index > last)) begin
						status_q <= ST_BAD_INDEX;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_POS: begin
				pos_q   <= pos_d;
				clamp_q <= sample_q[SAMPLE_W-1];
			end
			S_RDB: begin
				a_q <= rd_data;
			end
			S_MUL: begin
				prod_q <= prod_d;
			end
			S_SUM: begin
				if (single) begin
					res_q <= a_q;
				end else begin
					res_q <= sum_d[2*VAL_W-1:VAL_W];
				end
			end
			S_BGUESS: begin
				sample_q <= guess_sum[SAMPLE_W:1];
			end
			S_BMUL: begin
				r_q <= r_d;
			end
			S_BCMP: begin
				if (r_q < target) begin
					lo_q <= sample_q;
				end else if (r_q > target) begin
					hi_q <= sample_q;
				end
				k_q <= k_q + STEP_W'(1);
			end
			S_BWR: begin
				j_q  <= j_q + IDX_W'(1);
				lo_q <= '0;
				hi_q <= ONE_S;
				k_q  <= '0;
				res_q <= '0;
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= res_q;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tcli_pkg::*;

	localparam longint unsigned ONE = 64'd1 << VAL_W;
	localparam int QUIET_LIMIT    = 100000;
	localparam int STALL_CYCLES   = 300;
	localparam int BUILD_SIZE_MAX = 129;
	localparam int PHASE_ITEMS    = 50;
	localparam int MODE1_START    = 250;
	localparam int MODE2_START    = 500;
	localparam int MAX_REPORTS    = 10;
	localparam bit CHECK_TYPED    = 1'b1;
	localparam bit CHECK_PRED     = 1'b0;

	typedef struct {
		req_type_t             kind;
		logic [IDX_W-1:0]      idx;
		logic [VAL_W-1:0]      val;
		logic [SAMPLE_W-1:0]   smp;
	} req_word_t;

	typedef struct {
		logic [VAL_W-1:0]      value;
		status_t               status;
	} rsp_word_t;

	typedef struct {
		bit                    is_size;
		logic [SIZE_W-1:0]     size_val;
		req_word_t             w;
		bit                    typed;
		rsp_word_t             want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	tcli_req_if req_if();
	tcli_rsp_if rsp_if();

	tone_curve_lut_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the block's tables and size register.
	bit [VAL_W-1:0]     fwd_curve [TABLE_DEPTH];
	bit [VAL_W-1:0]     inv_curve [TABLE_DEPTH];
	bit                 fwd_loaded [TABLE_DEPTH];
	bit                 inv_loaded [TABLE_DEPTH];
	logic [SIZE_W-1:0]  cfg_table_size = SIZE_W'(256);

	rsp_word_t   pending_rsp [$];
	rsp_word_t   oldest;
	stim_row_t   directed_rows [27];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          snd_idle_pct = 21;
	int          rcv_idle_pct = 80;
	int          random_sent = 0;
	bit          stall_request = 1'b0;

	always #6 clk = ~clk;

	// The block clamps the size register's value to the range the tables support.
	function automatic int unsigned active_size();
		if (cfg_table_size < 2)
			return 2;
		if (cfg_table_size > TABLE_DEPTH)
			return TABLE_DEPTH;
		return cfg_table_size;
	endfunction

	function automatic bit [VAL_W-1:0] curve_entry(input bit from_inv, input longint unsigned i);
		return from_inv ? inv_curve[i] : fwd_curve[i];
	endfunction

	function automatic bit entry_loaded(input bit from_inv, input longint unsigned i);
		return from_inv ? inv_loaded[i] : fwd_loaded[i];
	endfunction

	// Linear interpolation between two neighboring entries, rounded to nearest.
	function automatic bit [VAL_W-1:0] curve_at(input bit from_inv,
			input bit [SAMPLE_W-1:0] smp, input int unsigned sz);
		longint unsigned last, pos, idx, frac, a, b;
		last = sz - 1;
		if (smp >= ONE)
			return curve_entry(from_inv, last);
		pos = smp * last;
		idx = pos >> VAL_W;
		frac = pos & (ONE - 1);
		if (idx >= last)
			return curve_entry(from_inv, last);
		if (frac == 0)
			return curve_entry(from_inv, idx);
		a = curve_entry(from_inv, idx);
		b = curve_entry(from_inv, idx + 1);
		return VAL_W'((a * (ONE - frac) + b * frac + (ONE >> 1)) >> VAL_W);
	endfunction

	// True when every entry a lookup fetches has been written.
	function automatic bit reads_loaded(input bit from_inv, input bit [SAMPLE_W-1:0] smp,
			input int unsigned sz);
		longint unsigned last, idx;
		last = sz - 1;
		if (smp >= ONE)
			return entry_loaded(from_inv, last);
		idx = (smp * last) >> VAL_W;
		if (idx >= last)
			return entry_loaded(from_inv, last);
		return entry_loaded(from_inv, idx) && entry_loaded(from_inv, idx + 1);
	endfunction

	function automatic bit forward_ready(input int unsigned sz);
		for (int unsigned i = 0; i < sz; i++)
			if (!fwd_loaded[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Bisection of the forward curve for every inverse entry in use.
	function automatic void rebuild_inverse(input int unsigned sz);
		longint unsigned lo, hi, guess, r, target, res;
		for (int unsigned j = 0; j < sz; j++) begin
			lo = 0;
			hi = ONE;
			target = 64'(j) << VAL_W;
			for (int k = 0; k < BISECT_STEPS; k++) begin
				guess = (lo + hi) >> 1;
				r = 64'(curve_at(1'b0, SAMPLE_W'(guess), sz)) * 64'(sz - 1);
				if (r < target)
					lo = guess;
				else if (r > target)
					hi = guess;
			end
			res = (lo + hi + 1) >> 1;
			if (res > ONE - 1)
				res = ONE - 1;
			inv_curve[j] = VAL_W'(res);
			inv_loaded[j] = 1'b1;
		end
	endfunction

	// Applies one request to the shadow state and returns its response word.
	function automatic rsp_word_t predict_response(input req_word_t w);
		rsp_word_t r;
		int unsigned sz;
		sz = active_size();
		r.value = '0;
		r.status = ST_OK;
		case (w.kind)
			REQ_LOAD: begin
				if (w.idx < sz) begin
					fwd_curve[w.idx] = w.val;
					fwd_loaded[w.idx] = 1'b1;
				end else begin
					r.status = ST_BAD_INDEX;
				end
			end
			REQ_BUILD: begin
				rebuild_inverse(sz);
				r.status = ST_BUILD_DONE;
			end
			REQ_TO_LIN: r.value = curve_at(1'b0, w.smp, sz);
			default: r.value = curve_at(1'b1, w.smp, sz);
		endcase
		return r;
	endfunction

	function automatic stim_row_t stim_row(input req_type_t k, input int idx, input int val,
			input int smp, input bit typed, input int ev, input status_t es);
		stim_row_t r;
		r.is_size = 1'b0;
		r.size_val = '0;
		r.w = '{kind: k, idx: IDX_W'(idx), val: VAL_W'(val), smp: SAMPLE_W'(smp)};
		r.typed = typed;
		r.want = '{value: VAL_W'(ev), status: es};
		return r;
	endfunction

	function automatic stim_row_t size_row(input int v);
		stim_row_t r;
		r = stim_row(REQ_LOAD, 0, 0, 0, CHECK_PRED, 0, ST_OK);
		r.is_size = 1'b1;
		r.size_val = SIZE_W'(v);
		return r;
	endfunction

	// Lookup samples weighted toward the edges and toward exact entry hits.
	function automatic bit [SAMPLE_W-1:0] random_sample();
		bit [VAL_W-1:0] low;
		low = VAL_W'($urandom);
		case ($urandom_range(0, 7))
			0: return {1'b1, low};
			1: return {1'b0, low[VAL_W-1:10], 10'd0};
			2: return SAMPLE_W'($urandom_range(0, 255));
			3: return SAMPLE_W'($urandom_range(65280, 65535));
			default: return {1'b0, low};
		endcase
	endfunction

	// Offers one word, holding it until accepted, then records its response.
	task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
		rsp_word_t predicted;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= w.kind;
		req_if.entry_index <= w.idx;
		req_if.entry_value <= w.val;
		req_if.sample      <= w.smp;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = predict_response(w);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	// Stops offering words and waits until the block has answered everything.
	task automatic drain_block();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write of the size register, done only while the block is idle.
	task automatic write_table_size(input logic [SIZE_W-1:0] sz);
		drain_block();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_TABLE_SIZE);
		pwdata  <= PDATA_W'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_table_size = sz;
	endtask

	// Random-part words also step the idling pattern as the run goes on.
	task automatic emit(input req_word_t w);
		if (random_sent == MODE1_START) begin
			snd_idle_pct = 80;
			rcv_idle_pct = 21;
		end else if (random_sent == MODE2_START) begin
			snd_idle_pct = 0;
			rcv_idle_pct = 0;
			stall_request = 1'b1;
		end
		random_sent++;
		send_word(w, CHECK_PRED, '{value: '0, status: ST_OK});
	endtask

	// Response ready, with one long hold-off on request.
	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (stall_request) begin
				stall_request = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Compare each accepted response word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected word: value %h status %0d", $time,
						rsp_if.value, rsp_if.status);
			end else begin
				oldest = pending_rsp.pop_front();
				if (rsp_if.value !== oldest.value || rsp_if.status !== oldest.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected value %h status %0d, got value %h status %0d",
							$time, oldest.value, oldest.status, rsp_if.value, rsp_if.status);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		bit [SIZE_W-1:0] phase_sizes [8];
		req_word_t       w;
		int unsigned     sz;
		int              shape;
		int              v;
		int              pick;
		bit              found;

		req_if.valid       <= 1'b0;
		req_if.req_type    <= REQ_LOAD;
		req_if.entry_index <= '0;
		req_if.entry_value <= '0;
		req_if.sample      <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset size, clamped sizes, edge samples, ramp and flat-curve builds.
		directed_rows = '{
			stim_row(REQ_LOAD, 256, 'h1234, 0, CHECK_TYPED, 0, ST_BAD_INDEX),
			stim_row(REQ_LOAD, 1023, 'hFFFF, 0, CHECK_TYPED, 0, ST_BAD_INDEX),
			stim_row(REQ_LOAD, 255, 'hFFFF, 0, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_LOAD, 0, 0, 'h1FFFF, CHECK_TYPED, 0, ST_OK),
			size_row(2),
			stim_row(REQ_LOAD, 1, 'hFFFF, 0, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_LOAD, 2, 'h5555, 0, CHECK_TYPED, 0, ST_BAD_INDEX),
			stim_row(REQ_TO_LIN, 0, 0, 0, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'h10000, CHECK_TYPED, 'hFFFF, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'h1FFFF, CHECK_TYPED, 'hFFFF, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'h8000, CHECK_TYPED, 'h8000, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'hFFFF, CHECK_PRED, 0, ST_OK),
			stim_row(REQ_BUILD, 0, 0, 0, CHECK_TYPED, 0, ST_BUILD_DONE),
			stim_row(REQ_FROM_LIN, 0, 0, 0, CHECK_PRED, 0, ST_OK),
			stim_row(REQ_FROM_LIN, 0, 0, 'h10000, CHECK_PRED, 0, ST_OK),
			stim_row(REQ_FROM_LIN, 0, 0, 'h4000, CHECK_PRED, 0, ST_OK),
			size_row(1),
			stim_row(REQ_LOAD, 2, 'h0F0F, 0, CHECK_TYPED, 0, ST_BAD_INDEX),
			stim_row(REQ_LOAD, 1, 0, 0, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'h1FFFF, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_BUILD, 0, 0, 0, CHECK_TYPED, 0, ST_BUILD_DONE),
			stim_row(REQ_FROM_LIN, 0, 0, 0, CHECK_PRED, 0, ST_OK),
			stim_row(REQ_FROM_LIN, 0, 0, 'h1FFFF, CHECK_PRED, 0, ST_OK),
			size_row(2047),
			stim_row(REQ_LOAD, 1023, 'hABCD, 0, CHECK_TYPED, 0, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 'h10000, CHECK_TYPED, 'hABCD, ST_OK),
			stim_row(REQ_TO_LIN, 0, 0, 0, CHECK_TYPED, 0, ST_OK)
		};
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_size)
				write_table_size(directed_rows[i].size_val);
			else
				send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
		end

		// Random part: per size, load a fresh curve and build if the size is at most BUILD_SIZE_MAX, then mixed traffic.
		phase_sizes = '{11'd5, 11'd65, 11'd0, 11'd129, 11'd17, 11'd33, 11'd1024, 11'd100};
		foreach (phase_sizes[p]) begin
			write_table_size(phase_sizes[p]);
			sz = active_size();
			if (sz <= BUILD_SIZE_MAX) begin
				shape = $urandom_range(0, 2);
				v = $urandom_range(0, 2000);
				for (int j = 0; j < sz; j++) begin
					case (shape)
						0: v = (j * 65535) / (sz - 1);
						1: v = $urandom_range(0, 65535);
						default: begin
							v = v + $urandom_range(0, (2 * 65535) / (sz - 1));
							if (v > 65535)
								v = 65535;
						end
					endcase
					w = '{kind: REQ_LOAD, idx: IDX_W'(j), val: VAL_W'(v), smp: SAMPLE_W'($urandom)};
					emit(w);
				end
				w = '{kind: REQ_BUILD, idx: IDX_W'($urandom), val: VAL_W'($urandom),
					smp: SAMPLE_W'($urandom)};
				emit(w);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				w.idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, sz - 1))
					: IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
				w.val = VAL_W'($urandom);
				w.smp = SAMPLE_W'($urandom);
				if (pick < 12) begin
					w.kind = REQ_LOAD;
				end else if (pick < 17 && sz <= BUILD_SIZE_MAX && forward_ready(sz)) begin
					w.kind = REQ_BUILD;
				end else begin
					w.kind = (pick < 58) ? REQ_TO_LIN : REQ_FROM_LIN;
					found = 1'b0;
					for (int t = 0; t < 16 && !found; t++) begin
						w.smp = random_sample();
						found = reads_loaded(w.kind == REQ_FROM_LIN, w.smp, sz);
					end
					if (!found)
						w.kind = REQ_LOAD;
				end
				emit(w);
			end
		end

		drain_block();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
